>>> rtl/core/cle_pkg.sv
// Package for the circular list engine: command and status codes, the
// request and result beat structs, the cell operation codes and the FSM states.
// No dependencies.
`default_nettype none

package cle_pkg;

  typedef enum logic [1:0] {
    CMD_INS_FRONT = 2'd0,
    CMD_INS_BACK  = 2'd1,
    CMD_DELETE    = 2'd2,
    CMD_LIST      = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t               cmd;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] item;
    logic [5:0]         count;
    logic               last;
  } res_t;

  // Operation broadcast to every cell of the chain at once.
  typedef enum logic [2:0] {
    CELL_HOLD   = 3'd0,
    CELL_SHIFT  = 3'd1,
    CELL_APPEND = 3'd2,
    CELL_ROTATE = 3'd3,
    CELL_DROP   = 3'd4
  } cell_op_t;

  typedef struct packed {
    cell_op_t    op;
    logic [31:0] data;
    logic [31:0] wrap;
  } cell_ctrl_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_WALK = 1'b1
  } state_t;

endpackage

`default_nettype wire

>>> rtl/core/cle_cell.sv
// One cell of the list chain: a value register and a valid bit that load
// from the left or right neighbor, the new value or the wrap value.
// Depends on cle_pkg.
`default_nettype none

module cle_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cle_pkg::cell_ctrl_t ctrl,
  input  wire logic [31:0]        left_value,
  input  wire logic               left_valid,
  input  wire logic [31:0]        right_value,
  input  wire logic               right_valid,
  output logic [31:0]             value,
  output logic                    valid
);

  logic [31:0] value_next;
  logic        valid_next;

  always_comb begin
    value_next = value;
    valid_next = valid;
    case (ctrl.op)
      cle_pkg::CELL_SHIFT: begin
        value_next = left_value;
        valid_next = left_valid;
      end
      cle_pkg::CELL_APPEND: begin
        // Only the first empty cell behind the tail takes the new value.
        if (!valid && left_valid) begin
          value_next = ctrl.data;
          valid_next = 1'b1;
        end
      end
      cle_pkg::CELL_ROTATE: begin
        // The tail cell takes the head value; the others take their right.
        if (valid) begin
          value_next = right_valid ? right_value : ctrl.wrap;
        end
      end
      cle_pkg::CELL_DROP: begin
        value_next = right_value;
        valid_next = right_valid;
      end
      default: begin
        value_next = value;
        valid_next = valid;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/circular_list_engine_core.sv
// Top level of the circular list engine: command FSM, node count and the
// chain of list cells. Depends on cle_pkg and cle_cell.
`default_nettype none

// Usage
// A command beat (request.cmd, request.value) is taken at a rising edge where
// start is high and busy is low. Results come out as beats on result, each
// marked by done for exactly one cycle; the receiver cannot stall them.
// The list is kept in logical order in a row of CAPACITY cells, the head in
// cell 0. Every command ends with a beat whose last bit is set.
// Insert front shifts the whole row right by one; insert back loads the first
// empty cell. Neither holds busy: the result beat comes in the cycle after
// acceptance, so inserts may come every cycle.
// Delete and list rotate the occupied cells left by one position per cycle
// until the row is back in its starting order. A list emits the head cell's
// value each cycle, its first beat registered after the state register has
// entered the walk; a delete drops the head cell on the first rotation step
// where its value equals the key and reports once at the end. These commands
// hold busy for the whole walk, so no command is taken until it ends.
// Commands on an empty list, or inserts into a full store, answer in the cycle after acceptance.
// Reset empties the list: all valid bits and the count clear at once.

module circular_list_engine_core #(
  parameter int CAPACITY = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire cle_pkg::req_t request,
  output logic               busy,
  output logic               done,
  output cle_pkg::res_t      result
);

  localparam int CW = $clog2(CAPACITY + 1);

  cle_pkg::state_t     state, state_next;
  logic [CW-1:0]       count, count_next;
  logic [CW-1:0]       steps, steps_next;
  logic                found, found_next;
  logic                walk_list, walk_list_next;
  logic [31:0]         key, key_next;
  cle_pkg::res_t       res_next;
  logic                done_next;
  cle_pkg::cell_ctrl_t cell_ctrl;

  logic [31:0]         cell_value [CAPACITY];
  logic [CAPACITY-1:0] cell_valid;

  logic                accept;
  logic                full;
  logic                hit;
  logic [6:0]          count_wide;

  assign accept = start && !busy;
  assign busy   = (state == cle_pkg::ST_WALK);
  assign full   = (count == CW'(CAPACITY));
  // The count field reports the node count modulo 64.
  assign count_wide = 7'(count_next);
  assign hit = !found && (cell_value[0] == key);

  // Row of cells; cell 0 holds the head, the occupied cells are contiguous.
  for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
    logic [31:0] lv;
    logic        lval;
    logic [31:0] rv;
    logic        rval;

    if (j == 0) begin : g_first
      assign lv   = cell_ctrl.data;
      assign lval = 1'b1;
    end else begin : g_mid_left
      assign lv   = cell_value[j-1];
      assign lval = cell_valid[j-1];
    end

    if (j == CAPACITY - 1) begin : g_last
      assign rv   = '0;
      assign rval = 1'b0;
    end else begin : g_mid_right
      assign rv   = cell_value[j+1];
      assign rval = cell_valid[j+1];
    end

    cle_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (cell_ctrl),
      .left_value  (lv),
      .left_valid  (lval),
      .right_value (rv),
      .right_valid (rval),
      .value       (cell_value[j]),
      .valid       (cell_valid[j])
    );
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    steps_next     = steps;
    found_next     = found;
    walk_list_next = walk_list;
    key_next       = key;
    done_next      = 1'b0;
    cell_ctrl.op   = cle_pkg::CELL_HOLD;
    cell_ctrl.data = request.value;
    cell_ctrl.wrap = cell_value[0];
    res_next       = '0;

    case (state)
      cle_pkg::ST_IDLE: begin
        if (accept) begin
          done_next     = 1'b1;
          res_next.last = 1'b1;
          case (request.cmd)
            cle_pkg::CMD_INS_FRONT, cle_pkg::CMD_INS_BACK: begin
              if (full) begin
                res_next.status = cle_pkg::STAT_FULL;
              end else begin
                cell_ctrl.op = (request.cmd == cle_pkg::CMD_INS_FRONT) ?
                               cle_pkg::CELL_SHIFT : cle_pkg::CELL_APPEND;
                count_next      = count + 1'b1;
                res_next.status = cle_pkg::STAT_OK;
              end
            end
            cle_pkg::CMD_DELETE, cle_pkg::CMD_LIST: begin
              if (count == '0) begin
                res_next.status = cle_pkg::STAT_EMPTY;
              end else begin
                // Results come from the walk instead.
                done_next      = 1'b0;
                state_next     = cle_pkg::ST_WALK;
                steps_next     = count;
                found_next     = 1'b0;
                key_next       = request.value;
                walk_list_next = (request.cmd == cle_pkg::CMD_LIST);
              end
            end
            default: begin
              res_next.status = cle_pkg::STAT_EMPTY;
            end
          endcase
          res_next.count = count_wide[5:0];
        end
      end
      cle_pkg::ST_WALK: begin
        steps_next = steps - 1'b1;
        if (steps == CW'(1)) begin
          state_next = cle_pkg::ST_IDLE;
        end
        if (walk_list) begin
          cell_ctrl.op    = cle_pkg::CELL_ROTATE;
          done_next       = 1'b1;
          res_next.status = cle_pkg::STAT_OK;
          res_next.item   = cell_value[0];
          res_next.last   = (steps == CW'(1));
        end else begin
          if (hit) begin
            cell_ctrl.op = cle_pkg::CELL_DROP;
            count_next   = count - 1'b1;
            found_next   = 1'b1;
          end else begin
            cell_ctrl.op = cle_pkg::CELL_ROTATE;
          end
          if (steps == CW'(1)) begin
            done_next       = 1'b1;
            res_next.last   = 1'b1;
            res_next.status = (found || hit) ? cle_pkg::STAT_OK
                                             : cle_pkg::STAT_NOT_FOUND;
          end
        end
        res_next.count = count_wide[5:0];
      end
      default: begin
        state_next = cle_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cle_pkg::ST_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    steps     <= steps_next;
    found     <= found_next;
    walk_list <= walk_list_next;
    key       <= key_next;
    result    <= res_next;
  end

  // The node count always equals the number of occupied cells.
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    $countones(cell_valid) == int'(count))
    else $error("node count disagrees with occupied cells");

  // Occupied cells form one run starting at the head cell.
  a_contiguous: assert property (@(posedge clk) disable iff (rst)
    (cell_valid & (cell_valid + 1'b1)) == '0)
    else $error("occupied cells are not contiguous from the head");

  // A listing walk emits a beat on every step.
  a_list_beats: assert property (@(posedge clk) disable iff (rst)
    (state == cle_pkg::ST_WALK && walk_list) |=> done)
    else $error("listing step without a result beat");

  // A refused insert only happens with every cell occupied.
  a_full_refusal: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == cle_pkg::STAT_FULL) |-> (count == CW'(CAPACITY)))
    else $error("store full reported with free cells");

  // No command is taken while a walk is running.
  a_no_accept_in_walk: assert property (@(posedge clk) disable iff (rst)
    (state == cle_pkg::ST_WALK) |-> !accept)
    else $error("command accepted during a walk");

endmodule

`default_nettype wire
